// ===== rtl/attribute_bitmap_cell_renderer_core_macros.svh =====
// Assertion macros used by the checker file of the renderer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ATTRIBUTE_BITMAP_CELL_RENDERER_CORE_MACROS_SVH
`define ATTRIBUTE_BITMAP_CELL_RENDERER_CORE_MACROS_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define ABCR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold at the clock edge after the antecedent.
`define ABCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/abcr_pkg.sv =====
package abcr_pkg;

    // Display geometry.
    localparam int TOP_BORDER_LINES  = 24;
    localparam int ACTIVE_LINES      = 192;
    localparam int SIDE_BORDER_CELLS = 4;
    localparam int CELLS_PER_ROW     = 32;

    // Store sizes and address widths.
    localparam int BITMAP_BYTES = 6144;
    localparam int ATTR_BYTES   = 768;
    localparam int BM_AW        = 13;
    localparam int AT_AW        = 10;

    // Queue sizes.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;

    // Input operation codes.
    localparam logic [1:0] OP_WR_BITMAP = 2'd0;
    localparam logic [1:0] OP_WR_ATTR   = 2'd1;
    localparam logic [1:0] OP_RENDER    = 2'd2;

    // Classified work passed from the front end to the back end.
    typedef enum logic [1:0] {
        KIND_WR_BITMAP,
        KIND_WR_ATTR,
        KIND_BORDER,
        KIND_CELL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BM_AW-1:0]   bm_addr;
        logic [AT_AW-1:0]   at_addr;
        logic [7:0]         data;
        logic               flash;
    } cmd_t;

    typedef logic [3:0][31:0] cell_words_t;

    // Fixed RGB332 palette; the upper eight entries are the bright set.
    function automatic logic [7:0] palette_byte(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h00;
            4'd1:    val = 8'h02;
            4'd2:    val = 8'hA0;
            4'd3:    val = 8'hA2;
            4'd4:    val = 8'h14;
            4'd5:    val = 8'h16;
            4'd6:    val = 8'hB4;
            4'd7:    val = 8'hB6;
            4'd8:    val = 8'h00;
            4'd9:    val = 8'h03;
            4'd10:   val = 8'hE0;
            4'd11:   val = 8'hE3;
            4'd12:   val = 8'h1C;
            4'd13:   val = 8'h1F;
            4'd14:   val = 8'hFC;
            default: val = 8'hFF;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/abcr_front.sv =====
module abcr_front (
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             op,
    input  logic [12:0]            address,
    input  logic [7:0]             data,
    input  logic [7:0]             line,
    input  logic [5:0]             column,
    input  logic [7:0]             frame,
    input  logic                   q_full,
    input  logic                   clearing,
    output logic                   cmd_push,
    output abcr_pkg::cmd_t         cmd
);

    logic       line_active;
    logic       col_active;
    logic [7:0] v;
    logic [5:0] c;
    logic       keep;

    // The input side stalls while the stores are being cleared or the queue is full.
    assign full = q_full || clearing;

    // Active window test and cell coordinates inside the active area.
    assign line_active = (line >= 8'(abcr_pkg::TOP_BORDER_LINES)) &&
                         (line < 8'(abcr_pkg::TOP_BORDER_LINES + abcr_pkg::ACTIVE_LINES));
    assign col_active  = (column >= 6'(abcr_pkg::SIDE_BORDER_CELLS)) &&
                         (column < 6'(abcr_pkg::SIDE_BORDER_CELLS + abcr_pkg::CELLS_PER_ROW));
    assign v = line - 8'(abcr_pkg::TOP_BORDER_LINES);
    assign c = column - 6'(abcr_pkg::SIDE_BORDER_CELLS);

    // Classify the transaction; dropped items never enter the queue.
    always_comb
    begin
        keep         = 1'b0;
        cmd.kind     = abcr_pkg::KIND_BORDER;
        cmd.bm_addr  = address;
        cmd.at_addr  = address[abcr_pkg::AT_AW-1:0];
        cmd.data     = data;
        cmd.flash    = frame[5];
        case (op)
            abcr_pkg::OP_WR_BITMAP:
            begin
                keep     = (address < 13'(abcr_pkg::BITMAP_BYTES));
                cmd.kind = abcr_pkg::KIND_WR_BITMAP;
            end
            abcr_pkg::OP_WR_ATTR:
            begin
                keep     = (address < 13'(abcr_pkg::ATTR_BYTES));
                cmd.kind = abcr_pkg::KIND_WR_ATTR;
            end
            abcr_pkg::OP_RENDER:
            begin
                keep = 1'b1;
                if (line_active && col_active)
                begin
                    cmd.kind    = abcr_pkg::KIND_CELL;
                    // Interleaved bitmap layout: third, pixel row, character row.
                    cmd.bm_addr = {v[7:6], v[2:0], v[5:3], c[4:0]};
                    cmd.at_addr = {v[7:3], c[4:0]};
                end
                else
                begin
                    cmd.kind = abcr_pkg::KIND_BORDER;
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign cmd_push = push && !full && keep;

endmodule

// ===== rtl/abcr_cmd_fifo.sv =====
module abcr_cmd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  abcr_pkg::cmd_t         wr_cmd,
    output logic                   q_full,
    input  logic                   rd_en,
    output logic                   q_valid,
    output abcr_pkg::cmd_t         rd_cmd
);

    abcr_pkg::cmd_t                 mem_reg [abcr_pkg::CMDQ_DEPTH];
    logic [abcr_pkg::CMDQ_AW-1:0]   wr_ptr_reg;
    logic [abcr_pkg::CMDQ_AW-1:0]   wr_ptr_next;
    logic [abcr_pkg::CMDQ_AW-1:0]   rd_ptr_reg;
    logic [abcr_pkg::CMDQ_AW-1:0]   rd_ptr_next;
    logic [abcr_pkg::CMDQ_AW:0]     count_reg;
    logic [abcr_pkg::CMDQ_AW:0]     count_next;

    assign q_full  = (count_reg == (abcr_pkg::CMDQ_AW+1)'(abcr_pkg::CMDQ_DEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_cmd  = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/abcr_back.sv =====
module abcr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  abcr_pkg::cmd_t         cmd,
    output logic                   cmd_pop,
    output logic                   clearing,
    input  logic                   cfg_write,
    input  logic [3:0]             cfg_data,
    output logic                   empty,
    input  logic                   pop,
    output logic [31:0]            word0,
    output logic [31:0]            word1,
    output logic [31:0]            word2,
    output logic [31:0]            word3
);

    // Stores.
    logic [7:0]                     bm_mem [abcr_pkg::BITMAP_BYTES];
    logic [7:0]                     at_mem [abcr_pkg::ATTR_BYTES];
    logic [7:0]                     bm_rdata_reg;
    logic [7:0]                     at_rdata_reg;

    // Clearing sweep after reset.
    logic                           clearing_reg;
    logic                           clearing_next;
    logic [abcr_pkg::BM_AW-1:0]     clr_addr_reg;
    logic [abcr_pkg::BM_AW-1:0]     clr_addr_next;

    logic [3:0]                     border_colour_reg;

    // Read stage.
    logic                           s1_valid_reg;
    logic                           s1_cell_reg;
    logic                           s1_flash_reg;

    // Result queue.
    abcr_pkg::cell_words_t          outq_reg [abcr_pkg::OUTQ_DEPTH];
    logic [abcr_pkg::OUTQ_AW-1:0]   oq_wr_ptr_reg;
    logic [abcr_pkg::OUTQ_AW-1:0]   oq_rd_ptr_reg;
    logic [abcr_pkg::OUTQ_AW:0]     oq_count_reg;
    logic [abcr_pkg::OUTQ_AW:0]     oq_count_next;

    logic                           is_write;
    logic                           is_render;
    logic                           credit;
    logic                           bm_we;
    logic [abcr_pkg::BM_AW-1:0]     bm_waddr;
    logic [7:0]                     wdata;
    logic                           at_we;
    logic [abcr_pkg::AT_AW-1:0]     at_waddr;
    logic                           rd_en;
    logic                           oq_push;
    logic                           oq_pop;
    logic [7:0]                     pix;
    logic [7:0]                     ink_b;
    logic [7:0]                     paper_b;
    logic [7:0]                     border_b;
    abcr_pkg::cell_words_t          cell_words;
    abcr_pkg::cell_words_t          head_words;

    assign clearing = clearing_reg;

    // Decode the queued command.
    always_comb
    begin
        is_write  = 1'b0;
        is_render = 1'b0;
        case (cmd.kind)
            abcr_pkg::KIND_WR_BITMAP: is_write  = 1'b1;
            abcr_pkg::KIND_WR_ATTR:   is_write  = 1'b1;
            abcr_pkg::KIND_BORDER:    is_render = 1'b1;
            abcr_pkg::KIND_CELL:      is_render = 1'b1;
            default:
            begin
                is_write  = 1'b0;
                is_render = 1'b0;
            end
        endcase
    end

    // A render may issue only if its result is sure to find room in the result queue.
    assign credit  = ((oq_count_reg + {{abcr_pkg::OUTQ_AW{1'b0}}, s1_valid_reg})
                      < (abcr_pkg::OUTQ_AW+1)'(abcr_pkg::OUTQ_DEPTH));
    assign cmd_pop = !clearing_reg && cmd_valid && (is_write || credit);

    // Store port control; the clearing sweep takes both write ports.
    always_comb
    begin
        if (clearing_reg)
        begin
            bm_we    = 1'b1;
            bm_waddr = clr_addr_reg;
            wdata    = 8'h00;
            at_we    = (clr_addr_reg < abcr_pkg::BM_AW'(abcr_pkg::ATTR_BYTES));
            at_waddr = clr_addr_reg[abcr_pkg::AT_AW-1:0];
        end
        else
        begin
            bm_we    = cmd_pop && (cmd.kind == abcr_pkg::KIND_WR_BITMAP);
            bm_waddr = cmd.bm_addr;
            wdata    = cmd.data;
            at_we    = cmd_pop && (cmd.kind == abcr_pkg::KIND_WR_ATTR);
            at_waddr = cmd.at_addr;
        end
    end

    assign rd_en = cmd_pop && (cmd.kind == abcr_pkg::KIND_CELL);

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= wdata;
        end
        if (rd_en)
        begin
            bm_rdata_reg <= bm_mem[cmd.bm_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (at_we)
        begin
            at_mem[at_waddr] <= wdata;
        end
        if (rd_en)
        begin
            at_rdata_reg <= at_mem[cmd.at_addr];
        end
    end

    // Clearing sweep sequencing.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == abcr_pkg::BM_AW'(abcr_pkg::BITMAP_BYTES - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg      <= 1'b1;
            clr_addr_reg      <= '0;
            border_colour_reg <= 4'd1;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            if (cfg_write)
            begin
                border_colour_reg <= cfg_data;
            end
            s1_valid_reg <= cmd_pop && is_render;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s1_cell_reg  <= (cmd.kind == abcr_pkg::KIND_CELL);
            s1_flash_reg <= cmd.flash;
        end
    end

    // Colour expansion: flash inversion, ink or paper per doubled pixel, or border.
    assign pix      = bm_rdata_reg ^ {8{at_rdata_reg[7] & s1_flash_reg}};
    assign ink_b    = abcr_pkg::palette_byte({at_rdata_reg[6], at_rdata_reg[2:0]});
    assign paper_b  = abcr_pkg::palette_byte(at_rdata_reg[6:3]);
    assign border_b = abcr_pkg::palette_byte(border_colour_reg);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (s1_cell_reg)
            begin
                cell_words[k][15:0]  = pix[7-2*k] ? {2{ink_b}} : {2{paper_b}};
                cell_words[k][31:16] = pix[6-2*k] ? {2{ink_b}} : {2{paper_b}};
            end
            else
            begin
                cell_words[k] = {4{border_b}};
            end
        end
    end

    // Result queue bookkeeping.
    assign oq_push = s1_valid_reg;
    assign oq_pop  = pop && !empty;
    assign empty   = (oq_count_reg == '0);

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (oq_pop && !oq_push)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + 1'b1;
            end
            oq_count_reg <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            outq_reg[oq_wr_ptr_reg] <= cell_words;
        end
    end

    assign head_words = outq_reg[oq_rd_ptr_reg];
    assign word0 = head_words[0];
    assign word1 = head_words[1];
    assign word2 = head_words[2];
    assign word3 = head_words[3];

endmodule

// ===== rtl/attribute_bitmap_cell_renderer_core.sv =====
// Bitmap and attribute cell renderer for a 256x192 display with a border.
// Input channel (push/full): each transaction is a bitmap byte write, an
// attribute byte write or a render request for one line and 16-pixel cell.
// A transaction is taken at a clock edge with push high and full low.
// Result channel (empty/pop): each render yields one transaction of four
// 32-bit RGB332 words, leftmost pixel in the lowest byte. Writes yield none.
// A render result passes the command queue, the store read registers and the
// result queue to reach the result ports. Throughput is one transaction per
// cycle while no sweep runs and no queue is full, set by the single read port
// of each store and the one-stage read pipeline. The user must write the
// border colour register through cfg_write and cfg_data while the block is
// idle; the block does not enforce this. It resets to palette entry 1. After
// reset both stores are swept to zero at one address per cycle; full stays
// high during the sweep, and config writes are still taken. When the receiver
// stalls, up to four results wait in the output queue and four commands in the
// command queue; once those fill up, full rises and input transactions wait.
module attribute_bitmap_cell_renderer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic [12:0] address,
    input  logic [7:0]  data,
    input  logic [7:0]  line,
    input  logic [5:0]  column,
    input  logic [7:0]  frame,
    input  logic        cfg_write,
    input  logic [3:0]  cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] word0,
    output logic [31:0] word1,
    output logic [31:0] word2,
    output logic [31:0] word3
);

    logic                   q_full;
    logic                   q_valid;
    logic                   clearing;
    logic                   cmd_push;
    logic                   cmd_pop;
    abcr_pkg::cmd_t         front_cmd;
    abcr_pkg::cmd_t         head_cmd;

    // Front end: input handshake and classification.
    abcr_front u_front (
        .push     (push),
        .full     (full),
        .op       (op),
        .address  (address),
        .data     (data),
        .line     (line),
        .column   (column),
        .frame    (frame),
        .q_full   (q_full),
        .clearing (clearing),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    // Command queue between the two halves.
    abcr_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_cmd  (front_cmd),
        .q_full  (q_full),
        .rd_en   (cmd_pop),
        .q_valid (q_valid),
        .rd_cmd  (head_cmd)
    );

    // Back end: stores, pixel expansion and result queue.
    abcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .word0     (word0),
        .word1     (word1),
        .word2     (word2),
        .word3     (word3)
    );

endmodule

// ===== rtl/abcr_checker.sv =====
`include "attribute_bitmap_cell_renderer_core_macros.svh"

module abcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] word0,
    input logic [31:0] word1,
    input logic [31:0] word2,
    input logic [31:0] word3
);

    // Coming out of reset, no result is pending and input is held off.
    `ABCR_ASSERT_SAME(a_reset_idle, $past(!rst_n), full && empty)

    // The store sweep keeps input held off past the first cycle after reset.
    `ABCR_ASSERT_NEXT(a_sweep_blocks, $past(!rst_n), full && empty)

    // A waiting result that is not taken stays in place unchanged.
    `ABCR_ASSERT_NEXT(a_result_holds, !empty && !pop,
        !empty && $stable(word0) && $stable(word1) && $stable(word2) && $stable(word3))

endmodule

bind attribute_bitmap_cell_renderer_core abcr_checker u_abcr_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .word0 (word0),
    .word1 (word1),
    .word2 (word2),
    .word3 (word3)
);
